FILE: hdl/keypad_code_lock_controller_unit_assert.svh
// assertion macros for the keypad code lock controller
// each check is sampled on clk and switched off while rst_n is low
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_UNIT_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define KCL_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kcl check failed");

`define KCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kcl sequence check failed");

`else

`define KCL_ASSERT_IMPLY(lbl, ante, cons)

`define KCL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/kcl_pkg.sv
package kcl_pkg;

  // digits in one code and the widths that follow from it
  localparam int CODE_DIGITS = 4;
  localparam int CODE_W      = 4 * CODE_DIGITS;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);

  localparam int MASTER_W = 16;
  localparam int LIMIT_W  = 4;
  localparam int CFG_W    = 16;

  localparam logic [MASTER_W-1:0] MASTER_RESET = 16'hDDDD;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd3;

  // configuration register indexes
  localparam logic CFG_MASTER_CODE   = 1'b0;
  localparam logic CFG_ATTEMPT_LIMIT = 1'b1;

  // request kinds
  localparam logic REQ_KEY    = 1'b0;
  localparam logic REQ_MOTION = 1'b1;

  // command keys, row*4+column
  localparam logic [3:0] KEY_A = 4'd3;
  localparam logic [3:0] KEY_D = 4'd15;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_CODE   = 2'd1,
    MODE_MASTER = 2'd2,
    MODE_NEW    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_CODE_OK    = 3'd1,
    ST_CODE_BAD   = 3'd2,
    ST_MASTER_OK  = 3'd3,
    ST_MASTER_BAD = 3'd4,
    ST_STORED     = 3'd5
  } status_t;

  typedef struct packed {
    logic       req_type;
    logic [3:0] key_code;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic       open_gate;
    logic       key_beep;
    logic       alarm_on;
    logic [1:0] entry_mode;
    logic [2:0] digits_entered;
    logic [3:0] tries_left;
  } out_item_t;

  typedef struct packed {
    logic [MASTER_W-1:0] master_code;
    logic [LIMIT_W-1:0]  attempt_limit;
  } cfg_t;

endpackage

FILE: hdl/keypad_code_lock_controller_unit.sv
// keypad code lock controller
// in_item carries one request: a key press (key_code = row*4+column of the
// 123A/456B/789C/*0#D pad) or a motion event. every request gives exactly one
// out_item with status, gate command, beep and the lock state after it.
// both channels: a request moves on a rising edge with valid high and stall
// low. the cfg port writes master_code (index 0) or attempt_limit (index 1)
// with cfg_we; write only while no request is in flight.
// a request is held in the input register, then the lock state is
// updated and the result is registered; out_valid comes from the result
// register. one request per cycle is sustained while out_stall is low; lock
// state changes with the result register, so back to back keys need no spacing.
// when the receiver stalls, the result register holds; one more request can
// wait in the input register, then in_stall rises until out_stall drops.
// a synchronous reset (rst_n low) empties both registers, goes idle with no
// digits, no stored user code, alarm off, tries 3, master code 0xDDDD and
// attempt limit 3.
`include "keypad_code_lock_controller_unit_assert.svh"

module keypad_code_lock_controller_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  kcl_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output kcl_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [kcl_pkg::CFG_W-1:0] cfg_wdata
);

  kcl_pkg::cfg_t      cfg;
  kcl_pkg::in_item_t  in_item_r;
  logic               in_valid_r;
  kcl_pkg::out_item_t out_item_r;
  logic               out_valid_r;
  kcl_pkg::out_item_t result;
  logic               advance;
  logic               step_en;

  // result register free or being drained this cycle
  assign advance  = ~out_valid_r | ~out_stall;
  assign step_en  = in_valid_r & advance;
  assign in_stall = in_valid_r & ~advance;

  kcl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kcl_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
    if (step_en) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `KCL_ASSERT_IMPLY(a_stall_only_when_full, in_stall, in_valid_r && out_valid_r && out_stall)
  `KCL_ASSERT_NEXT(a_request_moves_on, in_valid_r && !out_stall, out_valid_r)
  `KCL_ASSERT_IMPLY(a_grant_clears_alarm,
    out_valid_r && out_item_r.status == kcl_pkg::ST_CODE_OK,
    out_item_r.open_gate && !out_item_r.alarm_on)
  `KCL_ASSERT_IMPLY(a_idle_has_no_digits,
    out_valid_r && out_item_r.entry_mode == kcl_pkg::MODE_IDLE,
    out_item_r.digits_entered == 3'd0)

endmodule

FILE: hdl/kcl_cfg_regs.sv
module kcl_cfg_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_addr,
  input  logic [kcl_pkg::CFG_W-1:0] cfg_wdata,
  output kcl_pkg::cfg_t            cfg
);

  logic [kcl_pkg::MASTER_W-1:0] master_code_r;
  logic [kcl_pkg::LIMIT_W-1:0]  attempt_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_code_r   <= kcl_pkg::MASTER_RESET;
      attempt_limit_r <= kcl_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kcl_pkg::CFG_MASTER_CODE: begin
          master_code_r <= cfg_wdata[kcl_pkg::MASTER_W-1:0];
        end
        kcl_pkg::CFG_ATTEMPT_LIMIT: begin
          attempt_limit_r <= cfg_wdata[kcl_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.master_code   = master_code_r;
  assign cfg.attempt_limit = attempt_limit_r;

endmodule

FILE: hdl/kcl_core.sv
module kcl_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  kcl_pkg::in_item_t  item,
  input  kcl_pkg::cfg_t      cfg,
  output kcl_pkg::out_item_t result
);

  kcl_pkg::mode_t mode_r, mode_nxt;
  logic [kcl_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [kcl_pkg::CODE_W-1:0]  entered_r, entered_nxt;
  logic [kcl_pkg::CODE_W-1:0]  user_code_r, user_code_nxt;
  logic                        user_valid_r, user_valid_nxt;
  logic [kcl_pkg::LIMIT_W-1:0] tries_r, tries_nxt;
  logic                        alarm_r, alarm_nxt;

  logic [kcl_pkg::CODE_W-1:0]  master;
  logic [kcl_pkg::CODE_W-1:0]  ent_shift;
  logic [kcl_pkg::CNT_W-1:0]   cnt_inc;
  logic                        full;
  logic [kcl_pkg::LIMIT_W-1:0] tries_dec;
  logic                        fail_alarm;
  logic                        master_hit;
  logic                        user_hit;
  kcl_pkg::status_t            status;
  logic                        gate;
  logic                        beep;

  assign master     = kcl_pkg::CODE_W'(cfg.master_code);
  // newest key goes into the low nibble, oldest falls off the top
  assign ent_shift  = kcl_pkg::CODE_W'({entered_r, item.key_code});
  assign cnt_inc    = cnt_r + kcl_pkg::CNT_W'(1);
  assign full       = (cnt_inc == kcl_pkg::CNT_W'(kcl_pkg::CODE_DIGITS));
  assign tries_dec  = (tries_r == '0) ? '0 : tries_r - kcl_pkg::LIMIT_W'(1);
  assign fail_alarm = alarm_r | (tries_dec == '0);
  assign master_hit = (ent_shift == master);
  assign user_hit   = user_valid_r && (ent_shift == user_code_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= kcl_pkg::MODE_IDLE;
      cnt_r        <= '0;
      entered_r    <= '0;
      user_valid_r <= 1'b0;
      tries_r      <= kcl_pkg::LIMIT_RESET;
      alarm_r      <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      cnt_r        <= cnt_nxt;
      entered_r    <= entered_nxt;
      user_valid_r <= user_valid_nxt;
      tries_r      <= tries_nxt;
      alarm_r      <= alarm_nxt;
    end
  end

  // stored code is only read once its valid flag is set
  always_ff @(posedge clk) begin
    user_code_r <= user_code_nxt;
  end

  always_comb begin
    mode_nxt       = mode_r;
    cnt_nxt        = cnt_r;
    entered_nxt    = entered_r;
    user_code_nxt  = user_code_r;
    user_valid_nxt = user_valid_r;
    tries_nxt      = tries_r;
    alarm_nxt      = alarm_r;
    status         = kcl_pkg::ST_NONE;
    gate           = 1'b0;
    beep           = 1'b0;
    if (step_en) begin
      if (item.req_type == kcl_pkg::REQ_MOTION) begin
        gate = 1'b1;
      end else begin
        beep = ~alarm_r;
        if (mode_r == kcl_pkg::MODE_NEW) begin
          // every key but D is a digit here
          if (item.key_code != kcl_pkg::KEY_D) begin
            if (full) begin
              user_code_nxt  = ent_shift;
              user_valid_nxt = 1'b1;
              status         = kcl_pkg::ST_STORED;
              mode_nxt       = kcl_pkg::MODE_IDLE;
              cnt_nxt        = '0;
              entered_nxt    = '0;
            end else begin
              entered_nxt = ent_shift;
              cnt_nxt     = cnt_inc;
            end
          end
        end else if (item.key_code == kcl_pkg::KEY_A) begin
          mode_nxt    = kcl_pkg::MODE_CODE;
          cnt_nxt     = '0;
          entered_nxt = '0;
        end else if (item.key_code == kcl_pkg::KEY_D) begin
          mode_nxt    = kcl_pkg::MODE_MASTER;
          cnt_nxt     = '0;
          entered_nxt = '0;
        end else if (mode_r == kcl_pkg::MODE_CODE) begin
          if (full) begin
            if (master_hit || user_hit) begin
              tries_nxt = cfg.attempt_limit;
              alarm_nxt = 1'b0;
              gate      = 1'b1;
              status    = kcl_pkg::ST_CODE_OK;
            end else begin
              tries_nxt = tries_dec;
              alarm_nxt = fail_alarm;
              status    = kcl_pkg::ST_CODE_BAD;
            end
            mode_nxt    = kcl_pkg::MODE_IDLE;
            cnt_nxt     = '0;
            entered_nxt = '0;
          end else begin
            entered_nxt = ent_shift;
            cnt_nxt     = cnt_inc;
          end
        end else if (mode_r == kcl_pkg::MODE_MASTER) begin
          if (full) begin
            if (master_hit) begin
              tries_nxt = cfg.attempt_limit;
              alarm_nxt = 1'b0;
              status    = kcl_pkg::ST_MASTER_OK;
              mode_nxt  = kcl_pkg::MODE_NEW;
            end else begin
              tries_nxt = tries_dec;
              alarm_nxt = fail_alarm;
              status    = kcl_pkg::ST_MASTER_BAD;
              mode_nxt  = kcl_pkg::MODE_IDLE;
            end
            cnt_nxt     = '0;
            entered_nxt = '0;
          end else begin
            entered_nxt = ent_shift;
            cnt_nxt     = cnt_inc;
          end
        end else begin
          // idle: plain digits are dropped
        end
      end
    end
  end

  assign result.status         = status;
  assign result.open_gate      = gate;
  assign result.key_beep       = beep;
  assign result.alarm_on       = alarm_nxt;
  assign result.entry_mode     = mode_nxt;
  assign result.digits_entered = 3'(cnt_nxt);
  assign result.tries_left     = tries_nxt;

endmodule
